>>> design/iyfp_pkg.sv
// Package for the yaw frame parser: sizes, status codes, register indexes
// and the result payload type. No dependencies.
package iyfp_pkg;

  localparam int RSVD_BYTES = 4;
  localparam int RSVD_CW    = 3;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 8;

  localparam logic [CFG_IW-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SETTLE_COUNT  = 2'd2;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'd85;
  localparam logic [7:0] HEADER_SECOND_RST = 8'd83;
  localparam logic [7:0] SETTLE_COUNT_RST  = 8'd6;

  localparam logic [1:0] ST_HEADING  = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_SETTLING = 2'd2;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic signed [15:0] heading;
  } result_t;

endpackage

>>> design/iyfp_if.sv
// Stream interfaces for the yaw frame parser: received bytes in, frame results out.
// Depends on nothing.
interface iyfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface iyfp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic signed [15:0] heading;

  modport source(output valid, output frame_status, output heading, input ready);
  modport sink(input valid, input frame_status, input heading, output ready);
endinterface

>>> design/imu_yaw_frame_parser.sv
// Top level of the yaw frame parser: byte parser, settling and heading logic.
// Depends on iyfp_pkg, iyfp_if and iyfp_out_skid.
//
//   port    | dir | handshake   | payload
//   rx      | in  | valid/ready | rx_byte[7:0]
//   result  | out | valid/ready | frame_status[1:0], heading[15:0] signed
//   cfg     | in  | cfg_write   | cfg_index[1:0], cfg_data[7:0]
//
// One byte per cycle while rx.ready is high; frame state updates as a byte is taken.
// The checksum byte's result goes to the output register, or the skid if stalled.
// rx.ready drops only while the skid stage holds a result behind a stalled output.
// Synchronous reset returns the parser to header search with settling active.
module imu_yaw_frame_parser
  import iyfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  iyfp_byte_if.sink         rx,
  iyfp_result_if.source     result,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam logic [3:0] PH_HDR1 = 4'd0;
  localparam logic [3:0] PH_HDR2 = 4'd1;
  localparam logic [3:0] PH_RSVD = 4'd2;
  localparam logic [3:0] PH_YAWL = 4'd3;
  localparam logic [3:0] PH_YAWH = 4'd4;
  localparam logic [3:0] PH_VL   = 4'd5;
  localparam logic [3:0] PH_VH   = 4'd6;
  localparam logic [3:0] PH_SUM  = 4'd7;

  localparam logic [3:0] PH_AFTER_HDR2 = (RSVD_BYTES > 0) ? PH_RSVD : PH_YAWL;
  localparam logic [RSVD_CW:0] RSVD_LAST = (RSVD_CW + 1)'(RSVD_BYTES);

  logic [7:0] header_first;
  logic [7:0] header_second;
  logic [7:0] settle_count;

  logic [3:0]         phase, phase_next;
  logic [RSVD_CW-1:0] rsvd_count, rsvd_count_next;
  logic [7:0]         running_sum, running_sum_next;
  logic [7:0]         yaw_low, yaw_high;
  logic               settling, settling_next;
  logic [7:0]         settle_counter, settle_counter_next;
  logic [15:0]        reference_yaw, reference_yaw_next;
  logic [15:0]        current_heading, current_heading_next;

  logic       accept;
  logic       emit;
  result_t    emit_data;
  result_t    out_data;
  logic [7:0] b;
  logic [15:0] neg_yaw;
  logic [7:0]  sum_plus;

  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign sum_plus = running_sum + b;
  assign neg_yaw  = 16'd0 - {yaw_high, yaw_low};

  always_comb begin
    phase_next           = phase;
    rsvd_count_next      = rsvd_count;
    running_sum_next     = running_sum;
    settling_next        = settling;
    settle_counter_next  = settle_counter;
    reference_yaw_next   = reference_yaw;
    current_heading_next = current_heading;
    emit                 = 1'b0;
    emit_data.frame_status = ST_BAD_SUM;
    unique case (phase)
      PH_HDR1: begin
        if (b == header_first) begin
          running_sum_next = b;
          phase_next       = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (b == header_second) begin
          running_sum_next = sum_plus;
          rsvd_count_next  = '0;
          phase_next       = PH_AFTER_HDR2;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_RSVD: begin
        running_sum_next = sum_plus;
        if ({1'b0, rsvd_count} + 1'b1 >= RSVD_LAST) begin
          rsvd_count_next = '0;
          phase_next      = PH_YAWL;
        end else begin
          rsvd_count_next = rsvd_count + 1'b1;
        end
      end
      PH_YAWL: begin
        running_sum_next = sum_plus;
        phase_next       = PH_YAWH;
      end
      PH_YAWH: begin
        running_sum_next = sum_plus;
        phase_next       = PH_VL;
      end
      PH_VL: begin
        running_sum_next = sum_plus;
        phase_next       = PH_VH;
      end
      PH_VH: begin
        running_sum_next = sum_plus;
        phase_next       = PH_SUM;
      end
      PH_SUM: begin
        emit       = 1'b1;
        phase_next = PH_HDR1;
        if (running_sum == b) begin
          if (settling) begin
            if (settle_counter >= settle_count) begin
              settling_next      = 1'b0;
              reference_yaw_next = neg_yaw;
            end else begin
              settle_counter_next = settle_counter + 1'b1;
            end
            emit_data.frame_status = ST_SETTLING;
          end else begin
            current_heading_next   = neg_yaw - reference_yaw;
            emit_data.frame_status = ST_HEADING;
          end
        end
      end
      default: phase_next = PH_HDR1;
    endcase
    emit_data.heading = current_heading_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first    <= HEADER_FIRST_RST;
      header_second   <= HEADER_SECOND_RST;
      settle_count    <= SETTLE_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        REG_SETTLE_COUNT:  settle_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR1;
      rsvd_count      <= '0;
      running_sum     <= '0;
      yaw_low         <= '0;
      yaw_high        <= '0;
      settling        <= 1'b1;
      settle_counter  <= '0;
      reference_yaw   <= '0;
      current_heading <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      rsvd_count      <= rsvd_count_next;
      running_sum     <= running_sum_next;
      settling        <= settling_next;
      settle_counter  <= settle_counter_next;
      reference_yaw   <= reference_yaw_next;
      current_heading <= current_heading_next;
      if (phase == PH_YAWL) yaw_low  <= b;
      if (phase == PH_YAWH) yaw_high <= b;
    end
  end

  iyfp_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (accept && emit),
    .up_data    (emit_data),
    .up_ready   (rx.ready),
    .down_valid (result.valid),
    .down_data  (out_data),
    .down_ready (result.ready)
  );

  assign result.frame_status = out_data.frame_status;
  assign result.heading      = out_data.heading;

endmodule

>>> design/iyfp_out_skid.sv
// Result register with a skid stage for the yaw frame parser.
// Depends on iyfp_pkg (result_t).
module iyfp_out_skid
  import iyfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  input  result_t up_data,
  output logic    up_ready,
  output logic    down_valid,
  output result_t down_data,
  input  logic    down_ready
);

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;

  assign up_ready   = !skid_valid;
  assign down_valid = main_valid;
  assign down_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (down_ready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= up_valid;
        main_data  <= up_data;
      end
    end else if (up_valid && up_ready) begin
      skid_valid <= 1'b1;
      skid_data  <= up_data;
    end
  end

endmodule
